// ===== hw/rtl/weighted_round_robin_peer_picker_assert.svh =====
// ----------------------------------------------------------------------------
// Peer picker assertion macros
// Clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ROUND_ROBIN_PEER_PICKER_ASSERT_SVH
`define WEIGHTED_ROUND_ROBIN_PEER_PICKER_ASSERT_SVH
// same-cycle implication
`define WRRPP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define WRRPP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hw/rtl/wrrpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Peer picker package
// Action codes, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
`default_nettype none
package wrrpp_pkg;

   typedef enum logic [1:0] {
      ACT_SET_PEER = 2'd0,
      ACT_BEGIN    = 2'd1,
      ACT_GET      = 2'd2,
      ACT_FREE     = 2'd3
   } action_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_BUSY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_PICK,
      ST_DIV,
      ST_FREE,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SET,
      CMD_CLEAR_TRIED,
      CMD_SINGLE_GET,
      CMD_SCAN_INIT,
      CMD_SCAN_STEP,
      CMD_PICK,
      CMD_SINGLE_FREE,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_FREE_UPD
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       single;
      logic       scan_last;
      logic       div_done;
      logic       need_div;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/wrrpp_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one action beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface wrrpp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [3:0]  peer_index;
   logic [7:0]  weight;
   logic        down;
   logic [7:0]  fail_limit;
   logic [15:0] fail_window;
   logic [15:0] conn_limit;
   logic [31:0] now;
   logic        failed;

   modport source (output valid, action, peer_index, weight, down, fail_limit,
                   fail_window, conn_limit, now, failed, input ready);
   modport sink (input valid, action, peer_index, weight, down, fail_limit,
                 fail_window, conn_limit, now, failed, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wrrpp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface wrrpp_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [3:0] chosen_peer;

   modport source (output valid, status, chosen_peer, input ready);
   modport sink (input valid, status, chosen_peer, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wrrpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Peer picker controller
// Sequences each action through the datapath and holds the response beat.
// ----------------------------------------------------------------------------
`default_nettype none
module wrrpp_ctrl
   import wrrpp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type dp_status,
   output      cmd_type       dp_cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = CMD_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               dp_cmd   = CMD_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (dp_status.action)
               ACT_SET_PEER: begin
                  dp_cmd   = CMD_SET;
                  state_in = ST_RESP;
               end
               ACT_BEGIN: begin
                  dp_cmd   = CMD_CLEAR_TRIED;
                  state_in = ST_RESP;
               end
               ACT_GET: begin
                  if (dp_status.single) begin
                     dp_cmd   = CMD_SINGLE_GET;
                     state_in = ST_RESP;
                  end else begin
                     dp_cmd   = CMD_SCAN_INIT;
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  if (dp_status.single) begin
                     dp_cmd   = CMD_SINGLE_FREE;
                     state_in = ST_RESP;
                  end else if (dp_status.need_div) begin
                     dp_cmd   = CMD_DIV_INIT;
                     state_in = ST_DIV;
                  end else begin
                     state_in = ST_FREE;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            dp_cmd = CMD_SCAN_STEP;
            if (dp_status.scan_last) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            dp_cmd   = CMD_PICK;
            state_in = ST_RESP;
         end
         ST_DIV: begin
            dp_cmd = CMD_DIV_STEP;
            if (dp_status.div_done) begin
               state_in = ST_FREE;
            end
         end
         ST_FREE: begin
            dp_cmd   = CMD_FREE_UPD;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/wrrpp_dp.sv =====
// ----------------------------------------------------------------------------
// Peer picker datapath
// Peer table, scan unit, weight divider and response registers.
// ----------------------------------------------------------------------------
`default_nettype none
module wrrpp_dp
   import wrrpp_pkg::*;
#(
   parameter int MAX_PEERS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   output      dp_status_type status,
   input  wire logic          csr_wr_en,
   input  wire logic [4:0]    csr_wr_data,
   input  wire logic [1:0]    req_action,
   input  wire logic [3:0]    req_peer_index,
   input  wire logic [7:0]    req_weight,
   input  wire logic          req_down,
   input  wire logic [7:0]    req_fail_limit,
   input  wire logic [15:0]   req_fail_window,
   input  wire logic [15:0]   req_conn_limit,
   input  wire logic [31:0]   req_now,
   input  wire logic          req_failed,
   output      logic          rsp_status,
   output      logic [3:0]    rsp_chosen_peer
);

   localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

   function automatic logic signed [13:0] sat_cw(input logic signed [16:0] v);
      logic signed [13:0] r;
      if (v > 17'sd8191) begin
         r = 14'sd8191;
      end else if (v < -17'sd8192) begin
         r = -14'sd8192;
      end else begin
         r = v[13:0];
      end
      return r;
   endfunction

   logic [7:0]         weight_ff   [MAX_PEERS];
   logic               down_ff     [MAX_PEERS];
   logic [7:0]         flimit_ff   [MAX_PEERS];
   logic [15:0]        fwin_ff     [MAX_PEERS];
   logic [15:0]        climit_ff   [MAX_PEERS];
   logic signed [13:0] cw_ff       [MAX_PEERS];
   logic [7:0]         ew_ff       [MAX_PEERS];
   logic [7:0]         fcnt_ff     [MAX_PEERS];
   logic [31:0]        chk_ff      [MAX_PEERS];
   logic [31:0]        acc_ff      [MAX_PEERS];
   logic [15:0]        conn_ff     [MAX_PEERS];
   logic [MAX_PEERS-1:0] tried_ff;
   logic [IW-1:0]      last_pick_ff;
   logic [4:0]         peer_count_ff;

   logic [1:0]         action_ff;
   logic [3:0]         idx_ff;
   logic [7:0]         weight_in_ff;
   logic               down_in_ff;
   logic [7:0]         set_flimit_ff;
   logic [15:0]        set_fwin_ff;
   logic [15:0]        set_climit_ff;
   logic [31:0]        now_ff;
   logic               failed_ff;

   logic [IW-1:0]      scan_idx_ff;
   logic [IW-1:0]      best_ff;
   logic signed [13:0] best_cw_ff;
   logic [14:0]        total_ff;
   logic               found_ff;
   logic [7:0]         quo_ff;
   logic [7:0]         rem_ff;
   logic [2:0]         div_cnt_ff;
   logic               rsp_status_ff;
   logic [IW-1:0]      rsp_pick_ff;

   logic [IW-1:0]      addr;
   logic [IW+3:0]      idx_ext;
   logic               idx_ok;
   logic [IW+4:0]      pc_m1;
   logic [IW-1:0]      last_idx;
   logic               single;
   logic [31:0]        age;
   logic               fail_block;
   logic               conn_full;
   logic               eligible;
   logic signed [13:0] cw_new;
   logic signed [16:0] pick_diff;
   logic [15:0]        conn_up;
   logic [15:0]        conn_dn;
   logic [8:0]         div_shift;
   logic [8:0]         div_sub;
   logic               div_ge;
   logic [IW+3:0]      pick_ext;

   assign idx_ext = {{IW{1'b0}}, idx_ff};
   assign idx_ok  = 32'(idx_ff) < 32'(MAX_PEERS);

   always_comb begin
      case (cmd)
         CMD_SET:        addr = idx_ext[IW-1:0];
         CMD_SCAN_STEP:  addr = scan_idx_ff;
         CMD_PICK:       addr = best_ff;
         CMD_SINGLE_GET: addr = '0;
         default:        addr = last_pick_ff;
      endcase
   end

   assign pc_m1 = (IW+5)'(peer_count_ff) - (IW+5)'(1);
   always_comb begin
      if (peer_count_ff == 5'd0) begin
         last_idx = '0;
      end else if (32'(peer_count_ff) > 32'(MAX_PEERS)) begin
         last_idx = IW'(MAX_PEERS - 1);
      end else begin
         last_idx = pc_m1[IW-1:0];
      end
   end
   assign single = (last_idx == '0);

   assign age        = now_ff - chk_ff[addr];
   assign fail_block = (flimit_ff[addr] != 8'd0) && (fcnt_ff[addr] >= flimit_ff[addr])
                       && (age <= 32'(fwin_ff[addr]));
   assign conn_full  = (climit_ff[addr] != 16'd0) && (conn_ff[addr] >= climit_ff[addr]);
   assign eligible   = !tried_ff[addr] && !down_ff[addr] && !fail_block && !conn_full;
   assign cw_new     = sat_cw(17'(cw_ff[addr]) + $signed({9'b0, ew_ff[addr]}));
   assign pick_diff  = 17'(best_cw_ff) - $signed({2'b0, total_ff});
   assign conn_up    = (conn_ff[addr] != 16'hFFFF) ? conn_ff[addr] + 16'd1 : conn_ff[addr];
   assign conn_dn    = (conn_ff[addr] != 16'd0) ? conn_ff[addr] - 16'd1 : conn_ff[addr];
   assign div_shift  = {rem_ff, quo_ff[7]};
   assign div_sub    = div_shift - {1'b0, flimit_ff[addr]};
   assign div_ge     = div_shift >= {1'b0, flimit_ff[addr]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PEERS; i++) begin
            weight_ff[i] <= '0;
            down_ff[i]   <= 1'b0;
            flimit_ff[i] <= '0;
            fwin_ff[i]   <= '0;
            climit_ff[i] <= '0;
            cw_ff[i]     <= '0;
            ew_ff[i]     <= '0;
            fcnt_ff[i]   <= '0;
            chk_ff[i]    <= '0;
            acc_ff[i]    <= '0;
            conn_ff[i]   <= '0;
         end
         tried_ff      <= '0;
         last_pick_ff  <= '0;
         peer_count_ff <= 5'd1;
      end else begin
         if (csr_wr_en) begin
            peer_count_ff <= csr_wr_data;
         end
         case (cmd)
            CMD_SET: begin
               if (idx_ok) begin
                  weight_ff[addr] <= weight_in_ff;
                  down_ff[addr]   <= down_in_ff;
                  flimit_ff[addr] <= set_flimit_ff;
                  fwin_ff[addr]   <= set_fwin_ff;
                  climit_ff[addr] <= set_climit_ff;
                  cw_ff[addr]     <= '0;
                  ew_ff[addr]     <= weight_in_ff;
                  fcnt_ff[addr]   <= '0;
                  chk_ff[addr]    <= '0;
                  acc_ff[addr]    <= '0;
                  conn_ff[addr]   <= '0;
               end
            end
            CMD_CLEAR_TRIED: begin
               tried_ff <= '0;
            end
            CMD_SINGLE_GET: begin
               if (!down_ff[addr] && !conn_full) begin
                  last_pick_ff  <= '0;
                  conn_ff[addr] <= conn_up;
               end
            end
            CMD_SCAN_STEP: begin
               if (eligible) begin
                  cw_ff[addr] <= cw_new;
                  if (ew_ff[addr] < weight_ff[addr]) begin
                     ew_ff[addr] <= ew_ff[addr] + 8'd1;
                  end
               end
            end
            CMD_PICK: begin
               if (found_ff) begin
                  last_pick_ff   <= addr;
                  tried_ff[addr] <= 1'b1;
                  cw_ff[addr]    <= sat_cw(pick_diff);
                  if (age > 32'(fwin_ff[addr])) begin
                     chk_ff[addr] <= now_ff;
                  end
                  conn_ff[addr] <= conn_up;
               end
            end
            CMD_SINGLE_FREE: begin
               conn_ff[addr] <= conn_dn;
            end
            CMD_FREE_UPD: begin
               if (failed_ff) begin
                  if (fcnt_ff[addr] != 8'hFF) begin
                     fcnt_ff[addr] <= fcnt_ff[addr] + 8'd1;
                  end
                  acc_ff[addr] <= now_ff;
                  chk_ff[addr] <= now_ff;
                  if (flimit_ff[addr] != 8'd0) begin
                     ew_ff[addr] <= (ew_ff[addr] > quo_ff) ? ew_ff[addr] - quo_ff : 8'd0;
                  end
               end else if (acc_ff[addr] < chk_ff[addr]) begin
                  fcnt_ff[addr] <= '0;
               end
               conn_ff[addr] <= conn_dn;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         case (cmd)
            CMD_LOAD: begin
               action_ff     <= req_action;
               idx_ff        <= req_peer_index;
               weight_in_ff  <= req_weight;
               down_in_ff    <= req_down;
               set_flimit_ff <= req_fail_limit;
               set_fwin_ff   <= req_fail_window;
               set_climit_ff <= req_conn_limit;
               now_ff        <= req_now;
               failed_ff     <= req_failed;
               rsp_status_ff <= STATUS_OK;
               rsp_pick_ff   <= '0;
            end
            CMD_SINGLE_GET: begin
               rsp_status_ff <= (down_ff[addr] || conn_full) ? STATUS_BUSY : STATUS_OK;
            end
            CMD_SCAN_INIT: begin
               scan_idx_ff <= '0;
               total_ff    <= '0;
               found_ff    <= 1'b0;
            end
            CMD_SCAN_STEP: begin
               scan_idx_ff <= scan_idx_ff + IW'(1);
               if (eligible) begin
                  total_ff <= total_ff + 15'(ew_ff[addr]);
                  if (!found_ff || (cw_new > best_cw_ff)) begin
                     best_ff    <= addr;
                     best_cw_ff <= cw_new;
                     found_ff   <= 1'b1;
                  end
               end
            end
            CMD_PICK: begin
               rsp_status_ff <= found_ff ? STATUS_OK : STATUS_BUSY;
               rsp_pick_ff   <= found_ff ? addr : '0;
            end
            CMD_DIV_INIT: begin
               quo_ff     <= weight_ff[addr];
               rem_ff     <= '0;
               div_cnt_ff <= '0;
            end
            CMD_DIV_STEP: begin
               rem_ff     <= div_ge ? div_sub[7:0] : div_shift[7:0];
               quo_ff     <= {quo_ff[6:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 3'd1;
            end
            default: begin
            end
         endcase
      end
   end

   assign pick_ext        = {4'b0, rsp_pick_ff};
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_peer = pick_ext[3:0];

   assign status.action    = action_type'(action_ff);
   assign status.single    = single;
   assign status.scan_last = (scan_idx_ff == last_idx);
   assign status.div_done  = (div_cnt_ff == 3'd7);
   assign status.need_div  = failed_ff && (flimit_ff[addr] != 8'd0);

endmodule
`default_nettype wire

// ===== hw/rtl/weighted_round_robin_peer_picker.sv =====
// ----------------------------------------------------------------------------
// Weighted round robin peer picker
// Smooth weighted round robin over a peer table with passive health checks.
// Usage: actions arrive as beats on req_chan (set_peer, begin_request, get,
// free); every action returns exactly one beat on rsp_chan with status and
// chosen_peer. csr_wr_en/csr_wr_data write peer_count, which the user must
// write only while the block is idle; the block itself does not enforce it.
// Set_peer, begin_request and single-peer get/free go straight to the response;
// other frees run the free update, after the 8-step weight divider if failed
// with a nonzero fail limit; multi-peer get scans peers in use one per cycle.
// One action is in flight at a time; the next request is taken in the cycle
// after the response beat is accepted.
// Reset clears the whole peer table, the tried mask and the last pick, and
// sets peer_count to one; req_chan is not ready while reset is high.
// When the receiver stalls, the response beat holds and req_chan stays not
// ready until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "weighted_round_robin_peer_picker_assert.svh"
module weighted_round_robin_peer_picker
   import wrrpp_pkg::*;
#(
   parameter int MAX_PEERS = 16
) (
   input wire logic       clock,
   input wire logic       reset,
   wrrpp_req_if.sink      req_chan,
   wrrpp_rsp_if.source    rsp_chan,
   input wire logic       csr_wr_en,
   input wire logic [4:0] csr_wr_data
);

   cmd_type       dp_cmd;
   dp_status_type dp_status;
   logic          req_ready;
   logic          rsp_valid;

   wrrpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   wrrpp_dp #(
      .MAX_PEERS (MAX_PEERS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_action      (req_chan.action),
      .req_peer_index  (req_chan.peer_index),
      .req_weight      (req_chan.weight),
      .req_down        (req_chan.down),
      .req_fail_limit  (req_chan.fail_limit),
      .req_fail_window (req_chan.fail_window),
      .req_conn_limit  (req_chan.conn_limit),
      .req_now         (req_chan.now),
      .req_failed      (req_chan.failed),
      .rsp_status      (rsp_chan.status),
      .rsp_chosen_peer (rsp_chan.chosen_peer)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   `WRRPP_ASSERT_NOW(a_one_in_flight, rsp_valid, !req_ready, "request taken while response pending")
   `WRRPP_ASSERT_NOW(a_busy_no_peer, rsp_valid && rsp_chan.status, rsp_chan.chosen_peer == 4'd0, "busy with nonzero peer")
   `WRRPP_ASSERT_NEXT(a_accept_blocks, req_chan.valid && req_ready, !req_ready && !rsp_valid, "accept not followed by work")

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Peer picker testbench
// Drives set_peer, begin_request, get and free beats with random idling on
// both channels, predicts each response with a smooth weighted round robin
// model of the peer table, and compares every response beat in order.
// ----------------------------------------------------------------------------
module tb;
   import wrrpp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPEERS = 16;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      action_type  action;
      logic [3:0]  peer_index;
      logic [7:0]  weight;
      logic        down;
      logic [7:0]  fail_limit;
      logic [15:0] fail_window;
      logic [15:0] conn_limit;
      logic [31:0] now;
      logic        failed;
   } action_beat_t;

   typedef struct {
      logic       status;
      logic [3:0] chosen_peer;
   } pick_result_t;

   typedef struct {
      action_beat_t beat;
      logic         known;
      pick_result_t result;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = 5'd0;

   wrrpp_req_if req_chan();
   wrrpp_rsp_if rsp_chan();

   weighted_round_robin_peer_picker DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // model state
   logic [4:0]  m_count;
   logic [7:0]  m_weight [NPEERS];
   logic        m_down [NPEERS];
   logic [7:0]  m_flimit [NPEERS];
   logic [15:0] m_fwin [NPEERS];
   logic [15:0] m_climit [NPEERS];
   int          m_cw [NPEERS];
   logic [7:0]  m_ew [NPEERS];
   logic [7:0]  m_fails [NPEERS];
   logic [31:0] m_checked [NPEERS];
   logic [31:0] m_accessed [NPEERS];
   logic [15:0] m_conns [NPEERS];
   logic [15:0] m_tried;
   logic [3:0]  m_last;

   pick_result_t pending_picks[$];
   int   error_count = 0;
   int   idle_count = 0;
   bit   idling_on = 1'b1;
   bit   hold_rsp = 1'b0;
   bit   long_hold_req = 1'b0;
   logic [31:0] clock_now = 32'd100;

   function automatic int sat_weight(int v);
      if (v > 8191) return 8191;
      if (v < -8192) return -8192;
      return v;
   endfunction

   function automatic bit conn_full(int p);
      return m_climit[p] != 0 && m_conns[p] >= m_climit[p];
   endfunction

   function automatic int peers_used();
      if (m_count == 0) return 1;
      if (m_count > NPEERS) return NPEERS;
      return m_count;
   endfunction

   function automatic void model_reset();
      for (int i = 0; i < NPEERS; i++) begin
         m_weight[i] = 0; m_down[i] = 0; m_flimit[i] = 0; m_fwin[i] = 0;
         m_climit[i] = 0; m_cw[i] = 0; m_ew[i] = 0; m_fails[i] = 0;
         m_checked[i] = 0; m_accessed[i] = 0; m_conns[i] = 0;
      end
      m_tried = 0;
      m_last = 0;
      m_count = 1;
   endfunction

   function automatic pick_result_t predict_pick(action_beat_t b);
      pick_result_t r;
      int n, best, total;
      bit found;
      logic [7:0] d;
      int p;
      r.status = STATUS_OK;
      r.chosen_peer = 0;
      n = peers_used();
      case (b.action)
         ACT_SET_PEER: begin
            p = b.peer_index;
            m_weight[p] = b.weight; m_down[p] = b.down; m_flimit[p] = b.fail_limit;
            m_fwin[p] = b.fail_window; m_climit[p] = b.conn_limit;
            m_cw[p] = 0; m_ew[p] = b.weight; m_fails[p] = 0;
            m_checked[p] = 0; m_accessed[p] = 0; m_conns[p] = 0;
         end
         ACT_BEGIN: m_tried = 0;
         ACT_GET: begin
            if (n == 1) begin
               if (m_down[0] || conn_full(0)) r.status = STATUS_BUSY;
               else begin
                  m_last = 0;
                  if (m_conns[0] != 16'hFFFF) m_conns[0]++;
               end
            end else begin
               found = 0; best = 0; total = 0;
               for (int i = 0; i < n; i++) begin
                  if (m_tried[i] || m_down[i]) continue;
                  if (m_flimit[i] != 0 && m_fails[i] >= m_flimit[i]
                      && 32'(b.now - m_checked[i]) <= 32'(m_fwin[i])) continue;
                  if (conn_full(i)) continue;
                  m_cw[i] = sat_weight(m_cw[i] + int'(m_ew[i]));
                  total += int'(m_ew[i]);
                  if (m_ew[i] < m_weight[i]) m_ew[i]++;
                  if (!found || m_cw[i] > m_cw[best]) begin
                     best = i;
                     found = 1;
                  end
               end
               if (!found) r.status = STATUS_BUSY;
               else begin
                  m_last = 4'(best);
                  m_tried[best] = 1'b1;
                  m_cw[best] = sat_weight(m_cw[best] - total);
                  if (32'(b.now - m_checked[best]) > 32'(m_fwin[best]))
                     m_checked[best] = b.now;
                  if (m_conns[best] != 16'hFFFF) m_conns[best]++;
                  r.chosen_peer = 4'(best);
               end
            end
         end
         default: begin
            p = m_last;
            if (n != 1) begin
               if (b.failed) begin
                  if (m_fails[p] != 8'hFF) m_fails[p]++;
                  m_accessed[p] = b.now;
                  m_checked[p] = b.now;
                  if (m_flimit[p] != 0) begin
                     d = m_weight[p] / m_flimit[p];
                     m_ew[p] = (m_ew[p] > d) ? m_ew[p] - d : 8'd0;
                  end
               end else if (m_accessed[p] < m_checked[p]) begin
                  m_fails[p] = 0;
               end
            end
            if (m_conns[p] != 0) m_conns[p]--;
         end
      endcase
      return r;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.action = ACT_BEGIN;
      req_chan.peer_index = 0; req_chan.weight = 0; req_chan.down = 0;
      req_chan.fail_limit = 0; req_chan.fail_window = 0; req_chan.conn_limit = 0;
      req_chan.now = 0; req_chan.failed = 0;
      rsp_chan.ready = 1'b0;
   end

   // response side with random stalls
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            @(negedge clock);
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // long receiver hold-off, counted here
   initial begin
      wait (long_hold_req);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(negedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_picks.size() == 0) begin
            $display("%0t: unexpected response status=%0b chosen_peer=%0d",
                     $realtime, rsp_chan.status, rsp_chan.chosen_peer);
            error_count++;
         end else begin
            pick_result_t e;
            e = pending_picks.pop_front();
            if (rsp_chan.status !== e.status)
               begin
               $display("%0t: status expected %0b actual %0b", $realtime, e.status,
                        rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.chosen_peer !== e.chosen_peer) begin
               $display("%0t: chosen_peer expected %0d actual %0d", $realtime,
                        e.chosen_peer, rsp_chan.chosen_peer);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_beat(action_beat_t b, bit known, pick_result_t kr);
      pick_result_t r;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.action <= b.action; req_chan.peer_index <= b.peer_index;
      req_chan.weight <= b.weight; req_chan.down <= b.down;
      req_chan.fail_limit <= b.fail_limit; req_chan.fail_window <= b.fail_window;
      req_chan.conn_limit <= b.conn_limit; req_chan.now <= b.now;
      req_chan.failed <= b.failed;
      do @(posedge clock); while (!req_chan.ready);
      r = predict_pick(b);
      if (known && (r.status !== kr.status || r.chosen_peer !== kr.chosen_peer))
         r = kr;
      pending_picks.push_back(known ? kr : r);
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic write_peer_count(logic [4:0] v);
      while (pending_picks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      m_count = v;
   endtask

   function automatic action_beat_t rand_beat(int n);
      action_beat_t b;
      int k;
      b.peer_index = 4'($urandom_range(0, 15));
      if (n > 1 && $urandom_range(0, 3) != 0) b.peer_index = 4'($urandom_range(0, n - 1));
      b.weight = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 10));
      b.down = ($urandom_range(0, 7) == 0);
      b.fail_limit = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      b.fail_window = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 20));
      b.conn_limit = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      k = $urandom_range(0, 19);
      if (k == 0) clock_now = $urandom;
      else clock_now = clock_now + $urandom_range(0, 8);
      b.now = clock_now;
      b.failed = $urandom_range(0, 2) == 0;
      k = $urandom_range(0, 99);
      if (k < 8) b.action = ACT_SET_PEER;
      else if (k < 28) b.action = ACT_BEGIN;
      else if (k < 64) b.action = ACT_GET;
      else b.action = ACT_FREE;
      return b;
   endfunction

   function automatic action_beat_t mk(action_type a, logic [3:0] idx, logic [7:0] w,
                                       logic dn, logic [7:0] mf, logic [15:0] ft,
                                       logic [15:0] mc, logic [31:0] nw, logic f);
      action_beat_t b;
      b.action = a; b.peer_index = idx; b.weight = w; b.down = dn; b.fail_limit = mf;
      b.fail_window = ft; b.conn_limit = mc; b.now = nw; b.failed = f;
      return b;
   endfunction

   initial begin
      directed_row_t rows[$];
      directed_row_t row;
      pick_result_t none;
      int phase_counts[] = '{16, 1, 3, 0, 31, 8, 2, 16, 5, 1};
      int n;
      none.status = STATUS_OK;
      none.chosen_peer = 0;
      model_reset();
      while (reset) @(negedge clock);

      // single-peer rules right after reset, then extremes with 16 peers
      row.known = 1; row.result = none;
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(ACT_FREE, 0, 0, 0, 0, 0, 0, 0, 1); rows.push_back(row);
      row.beat = mk(ACT_SET_PEER, 0, 255, 1, 255, 16'hFFFF, 16'hFFFF, 0, 0);
      rows.push_back(row);
      row.result.status = STATUS_BUSY;
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.result = none;
      row.beat = mk(ACT_SET_PEER, 0, 1, 0, 0, 0, 1, 0, 0); rows.push_back(row);
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0); rows.push_back(row);
      row.result.status = STATUS_BUSY;
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.result = none;
      row.beat = mk(ACT_FREE, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(ACT_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      foreach (rows[i]) send_beat(rows[i].beat, rows[i].known, rows[i].result);

      write_peer_count(5'd16);
      rows.delete();
      row.known = 0;
      row.beat = mk(ACT_SET_PEER, 15, 255, 0, 1, 16'hFFFF, 0, 0, 0); rows.push_back(row);
      row.beat = mk(ACT_SET_PEER, 1, 255, 0, 2, 5, 0, 0, 0); rows.push_back(row);
      row.beat = mk(ACT_SET_PEER, 2, 1, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 10, 0); rows.push_back(row);
      row.beat = mk(ACT_FREE, 0, 0, 0, 0, 0, 0, 11, 1); rows.push_back(row);
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 12, 0); rows.push_back(row);
      row.beat = mk(ACT_FREE, 0, 0, 0, 0, 0, 0, 13, 1); rows.push_back(row);
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 14, 0); rows.push_back(row);
      row.beat = mk(ACT_FREE, 0, 0, 0, 0, 0, 0, 15, 0); rows.push_back(row);
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 32'hFFFFFFF0, 0); rows.push_back(row);
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 32'hFFFFFFF0, 0); rows.push_back(row);
      row.beat = mk(ACT_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.beat = mk(ACT_GET, 0, 0, 0, 0, 0, 0, 20, 0); rows.push_back(row);
      foreach (rows[i]) send_beat(rows[i].beat, rows[i].known, rows[i].result);

      foreach (phase_counts[ph]) begin
         write_peer_count(5'(phase_counts[ph]));
         n = peers_used();
         if (ph == 4) long_hold_req = 1'b1;
         if (ph == phase_counts.size() - 1) idling_on = 1'b0;
         for (int j = 0; j < 120; j++) send_beat(rand_beat(n), 0, none);
      end

      while (pending_picks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/wrrpp_pkg.sv
hw/rtl/wrrpp_req_if.sv
hw/rtl/wrrpp_rsp_if.sv
hw/rtl/wrrpp_ctrl.sv
hw/rtl/wrrpp_dp.sv
hw/rtl/weighted_round_robin_peer_picker.sv
tb/sv/tb.sv
